### hw/rtl/pctt_pkg.sv
// Shared types, codes and constants for the phase clock with tap tempo.
package pctt_pkg;

  // Function codes of an input word
  localparam logic [2:0] FN_TICK   = 3'd0;
  localparam logic [2:0] FN_RESET  = 3'd1;
  localparam logic [2:0] FN_TAP    = 3'd2;
  localparam logic [2:0] FN_TEMPO  = 3'd3;
  localparam logic [2:0] FN_DIVIDE = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_MULT    = 3'd0;
  localparam logic [2:0] REG_EXT     = 3'd1;
  localparam logic [2:0] REG_RATE    = 3'd2;
  localparam logic [2:0] REG_MIN_IV  = 3'd3;
  localparam logic [2:0] REG_MAX_IV  = 3'd4;
  localparam logic [2:0] REG_THRESH  = 3'd5;

  // Configuration reset values
  localparam logic [4:0]  MULT_RST   = 5'd1;
  localparam logic [16:0] RATE_RST   = 17'd48000;
  localparam logic [31:0] MIN_IV_RST = 32'd4800;
  localparam logic [31:0] MAX_IV_RST = 32'd192000;
  localparam logic [31:0] THRESH_RST = 32'hF000_0000;

  // Tenths of BPM per tick-per-second
  localparam logic [26:0] TENTHS_PER_MIN = 27'd600;
  // Full phase turn, 2^32
  localparam logic [32:0] FULL_TURN = 33'h1_0000_0000;

  // Divider: one quotient bit per cycle
  localparam int DIV_STEPS = 33;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

  // Divider operand selection
  localparam logic [1:0] SRC_TEMPO = 2'd0;  // ticks/min over tempo
  localparam logic [1:0] SRC_TAP   = 2'd1;  // full turn over tap interval
  localparam logic [1:0] SRC_TICKS = 2'd2;  // full turn over ticks per beat

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       tick;
    logic       preset;
    logic       set_div;
    logic       tap_store;
    logic       tap_clear;
    logic       div_start;
    logic [1:0] div_src;
    logic       ld_step;
    logic       mul;
    logic       sat;
    logic       clr_bpm;
    logic       out_load;
  } pctt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic tap_first;
    logic tap_ok;
    logic iv_nz;
    logic tempo_nz;
    logic quot_nz;
    logic div_busy;
  } pctt_sts_t;

endpackage

### hw/rtl/pctt_div.sv
// Restoring divider, 33-bit dividend by 32-bit divisor, one bit per cycle.
module pctt_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [32:0] quot
);

  logic [pctt_pkg::DIV_CW-1:0] cnt;
  logic [31:0] rem;
  logic [32:0] quo;
  logic [31:0] dvs;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  // One trial subtraction per step
  assign trial = {rem, quo[32]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};
  assign busy  = cnt != '0;
  assign quot  = quo;

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= pctt_pkg::DIV_CW'(pctt_pkg::DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[31:0] : trial[31:0];
      quo <= {quo[31:0], ge};
    end
  end

endmodule

### hw/rtl/pctt_dp.sv
// Datapath: config registers, phase state, tap logic, divider and multiplier.
module pctt_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  pctt_pkg::pctt_cmd_t  cmd,
  output pctt_pkg::pctt_sts_t  sts,
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [31:0]          tap_time,
  input  logic [15:0]          bpm_tenths,
  input  logic [7:0]           new_divisor,
  output logic                 main_edge,
  output logic                 sub_edge,
  output logic [31:0]          phase_now,
  output logic [15:0]          tap_bpm,
  output logic [31:0]          tick_total
);

  // Configuration
  logic [4:0]  mult;
  logic        ext;
  logic [16:0] rate;
  logic [31:0] min_iv;
  logic [31:0] max_iv;
  logic [31:0] thresh;

  // Clock state
  logic [31:0] acc;
  logic [31:0] step;
  logic [31:0] tick_cnt;
  logic [31:0] last_tap;
  logic [7:0]  sub_cnt;
  logic [7:0]  ratio;
  logic        armed;
  logic        main_flag;
  logic        sub_flag;
  logic [15:0] bpm;

  // Latched payload and working registers
  logic [31:0] tap_q;
  logic [15:0] bpm_q;
  logic [7:0]  divr_q;
  logic [26:0] ticks_per_min;
  logic [58:0] prod;

  // Divider hookup
  logic [32:0] div_dividend;
  logic [31:0] div_divisor;
  logic [32:0] div_quot;
  logic        div_busy;

  // Tick arithmetic
  logic [32:0] sum;
  logic [31:0] pp;
  logic [31:0] sm;
  logic [31:0] cp;
  logic [7:0]  sub_inc;
  logic        hit;
  logic        armed_t;
  logic        armed_tick;
  logic [7:0]  sub_tick;

  // Phase reset guard
  logic        do_preset;
  logic        reset_ok;
  logic        apply_reset;
  logic [31:0] interval;

  // Config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mult   <= pctt_pkg::MULT_RST;
      ext    <= 1'b0;
      rate   <= pctt_pkg::RATE_RST;
      min_iv <= pctt_pkg::MIN_IV_RST;
      max_iv <= pctt_pkg::MAX_IV_RST;
      thresh <= pctt_pkg::THRESH_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        pctt_pkg::REG_MULT:   mult   <= cfg_data[4:0];
        pctt_pkg::REG_EXT:    ext    <= cfg_data[0];
        pctt_pkg::REG_RATE:   rate   <= cfg_data[16:0];
        pctt_pkg::REG_MIN_IV: min_iv <= cfg_data;
        pctt_pkg::REG_MAX_IV: max_iv <= cfg_data;
        pctt_pkg::REG_THRESH: thresh <= cfg_data;
        default: ;
      endcase
    end
  end

  // Ticks per minute follows the rate register (constant multiply)
  always_ff @(posedge clk) begin
    ticks_per_min <= {10'd0, rate} * pctt_pkg::TENTHS_PER_MIN;
  end

  // Payload latch at accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tap_q  <= tap_time;
      bpm_q  <= bpm_tenths;
      divr_q <= new_divisor;
    end
  end

  // Tick: next phase, subclock wrap test via (phase * mult) mod 2^32
  assign sum        = {1'b0, acc} + {1'b0, step};
  assign pp         = acc * {27'd0, mult};
  assign sm         = step * {27'd0, mult};
  assign cp         = pp + sm;
  assign sub_inc    = (pp > cp) ? sub_cnt + 8'd1 : sub_cnt;
  assign hit        = sub_inc >= ratio;
  assign armed_t    = hit | armed;
  assign sub_tick   = (hit || (armed_t && sum[32])) ? 8'd0 : sub_inc;
  assign armed_tick = armed_t & ~sum[32];

  // Phase reset is skipped near the top in external mode
  assign do_preset   = cmd.preset | (cmd.set_div & ext);
  assign reset_ok    = !(ext && (acc > thresh));
  assign apply_reset = do_preset & reset_ok;

  // Clock state update
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      main_flag <= 1'b0;
      sub_flag  <= 1'b0;
      sub_cnt   <= '0;
      armed     <= 1'b0;
      ratio     <= 8'd1;
      tick_cnt  <= '0;
    end else begin
      if (cmd.tick) begin
        acc       <= sum[31:0];
        main_flag <= sum[32];
        sub_flag  <= hit;
        sub_cnt   <= sub_tick;
        armed     <= armed_tick;
        tick_cnt  <= tick_cnt + 32'd1;
      end else if (apply_reset) begin
        acc       <= '0;
        main_flag <= 1'b1;
        armed     <= 1'b0;
      end else if (cmd.set_div) begin
        armed     <= 1'b1;
      end
      if (cmd.set_div) begin
        ratio <= divr_q;
      end
    end
  end

  // Tap interval and last tap
  assign interval = tap_q - last_tap;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_tap <= '0;
    end else if (cmd.tap_store) begin
      last_tap <= tap_q;
    end else if (cmd.tap_clear) begin
      last_tap <= '0;
    end
  end

  // Divider operand selection
  always_comb begin
    div_dividend = pctt_pkg::FULL_TURN;
    div_divisor  = interval;
    case (cmd.div_src)
      pctt_pkg::SRC_TEMPO: begin
        div_dividend = {6'd0, ticks_per_min};
        div_divisor  = {16'd0, bpm_q};
      end
      pctt_pkg::SRC_TAP:   div_divisor = interval;
      pctt_pkg::SRC_TICKS: div_divisor = div_quot[31:0];
      default: ;
    endcase
  end

  pctt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quot     (div_quot)
  );

  // Phase step, saturated at all ones
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (cmd.ld_step) begin
      step <= div_quot[32] ? 32'hFFFF_FFFF : div_quot[31:0];
    end
  end

  // Tempo of the step: step * ticks/min, upper word, saturated
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= {27'd0, step} * {32'd0, ticks_per_min};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bpm <= '0;
    end else if (cmd.clr_bpm) begin
      bpm <= '0;
    end else if (cmd.sat) begin
      bpm <= (|prod[58:48]) ? 16'hFFFF : prod[47:32];
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      main_edge  <= main_flag;
      sub_edge   <= sub_flag;
      phase_now  <= acc;
      tap_bpm    <= bpm;
      tick_total <= tick_cnt;
    end
  end

  // Status to controller
  assign sts.tap_first = last_tap == '0;
  assign sts.tap_ok    = !((interval < min_iv) || (interval > max_iv));
  assign sts.iv_nz     = interval != '0;
  assign sts.tempo_nz  = bpm_q != '0;
  assign sts.quot_nz   = div_quot[31:0] != '0;
  assign sts.div_busy  = div_busy;

endmodule

### hw/rtl/pctt_ctrl.sv
// Controller: sequences one word at a time through execute, divide and multiply steps.
module pctt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [2:0]           func,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pctt_pkg::pctt_cmd_t  cmd,
  input  pctt_pkg::pctt_sts_t  sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_DIV2 = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_SAT  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] func_q;
  logic       accept;
  logic       out_free;

  assign in_stall = state != S_IDLE;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Function code latch
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= func;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.load   = accept;
    cmd.div_src = pctt_pkg::SRC_TAP;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.clr_bpm = 1'b1;
        state_next  = S_DONE;
        case (func_q)
          pctt_pkg::FN_TICK:   cmd.tick    = 1'b1;
          pctt_pkg::FN_RESET:  cmd.preset  = 1'b1;
          pctt_pkg::FN_DIVIDE: cmd.set_div = 1'b1;
          pctt_pkg::FN_TAP: begin
            if (sts.tap_first) begin
              cmd.tap_store = 1'b1;
            end else if (!sts.tap_ok) begin
              cmd.tap_clear = 1'b1;
            end else begin
              cmd.tap_store = 1'b1;
              cmd.preset    = 1'b1;
              if (sts.iv_nz) begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV2;
              end else begin
                state_next = S_MUL;
              end
            end
          end
          pctt_pkg::FN_TEMPO: begin
            if (sts.tempo_nz) begin
              cmd.div_start = 1'b1;
              cmd.div_src   = pctt_pkg::SRC_TEMPO;
              state_next    = S_DIV1;
            end
          end
          default: ;
        endcase
      end
      // ticks per beat = ticks/min over tempo
      S_DIV1: begin
        if (!sts.div_busy) begin
          if (sts.quot_nz) begin
            cmd.div_start = 1'b1;
            cmd.div_src   = pctt_pkg::SRC_TICKS;
            state_next    = S_DIV2;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      // phase step = full turn over ticks
      S_DIV2: begin
        if (!sts.div_busy) begin
          cmd.ld_step = 1'b1;
          state_next  = (func_q == pctt_pkg::FN_TAP) ? S_MUL : S_DONE;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SAT;
      end
      S_SAT: begin
        cmd.sat    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // The divider is never restarted while running
  assert property (@(posedge clk) disable iff (rst) cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  // Only set tempo uses the first division
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV1) |-> (func_q == pctt_pkg::FN_TEMPO))
    else $error("first division outside set tempo");

  // Tempo multiply only follows a tap
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL || state == S_SAT) |-> (func_q == pctt_pkg::FN_TAP))
    else $error("tempo multiply outside tap");

  // A finished word always reaches the output register
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && state == S_IDLE))
    else $error("result word not delivered");

endmodule

### hw/rtl/phase_clock_with_tap_tempo_core.sv
// Top level of the phase accumulator clock with tap tempo.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------------
//  in       | in_valid / in_stall    | func, tap_time, bpm_tenths, new_divisor
//  out      | out_valid / out_stall  | main_edge, sub_edge, phase_now, tap_bpm, tick_total
//  config   | cfg_write              | cfg_index, cfg_data
//
// Tick, reset, divide, zero tempo, other codes, first or rejected tap: execute, then done.
// Accepted tap: one division (none if interval is 0), set tempo: two (one if ticks/beat is 0);
// each division runs in the shared 33-step divider, a tap adds multiply and saturate.
// One word is in work at a time; a new word is taken while the previous result waits.
// A stalled output holds the finished word in the controller until the register frees.
// rst is synchronous: clock state, config registers and control return to reset values.
module phase_clock_with_tap_tempo_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [31:0] tap_time,
  input  logic [15:0] bpm_tenths,
  input  logic [7:0]  new_divisor,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        main_edge,
  output logic        sub_edge,
  output logic [31:0] phase_now,
  output logic [15:0] tap_bpm,
  output logic [31:0] tick_total,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  pctt_pkg::pctt_cmd_t cmd;
  pctt_pkg::pctt_sts_t sts;

  pctt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .func      (func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  pctt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .tap_time    (tap_time),
    .bpm_tenths  (bpm_tenths),
    .new_divisor (new_divisor),
    .main_edge   (main_edge),
    .sub_edge    (sub_edge),
    .phase_now   (phase_now),
    .tap_bpm     (tap_bpm),
    .tick_total  (tick_total)
  );

endmodule
